FILE: hw/rtl/rrc_pkg.sv
package rrc_pkg;

  // Region codes on the result port
  typedef enum logic [3:0] {
    REGION_OUTSIDE   = 4'd0,
    REGION_TOP       = 4'd1,
    REGION_RIGHT     = 4'd2,
    REGION_BOTTOM    = 4'd3,
    REGION_LEFT      = 4'd4,
    REGION_CORNER_TL = 4'd5,
    REGION_CORNER_TR = 4'd6,
    REGION_CORNER_BR = 4'd7,
    REGION_CORNER_BL = 4'd8
  } region_t;

  // Sign and zero flags of the point's offsets from the base rectangle edges
  typedef struct packed {
    logic ox1_neg;   // px - left < 0
    logic ox1_zero;  // px - left == 0
    logic ox2_neg;   // px - right < 0
    logic ox2_zero;  // px - right == 0
    logic oy1_neg;   // py - top < 0
    logic oy2_neg;   // py - bottom < 0
    logic oy2_zero;  // py - bottom == 0
  } offset_flags_t;

endpackage

FILE: hw/rtl/rrc_products.sv
module rrc_products
  import rrc_pkg::*;
#(
  parameter int CB = 16
) (
  input  logic                   clk,
  input  logic signed [CB-1:0]   rect_left,
  input  logic signed [CB-1:0]   rect_top,
  input  logic        [CB-2:0]   rect_width,
  input  logic        [CB-2:0]   rect_height,
  input  logic        [CB-2:0]   corner_radius,
  input  logic signed [CB-1:0]   point_x,
  input  logic signed [CB-1:0]   point_y,
  output logic        [2*CB-1:0] sq_x1,
  output logic        [2*CB-1:0] sq_x2,
  output logic        [2*CB-1:0] sq_y1,
  output logic        [2*CB-1:0] sq_y2,
  output logic        [2*CB-3:0] r_sq,
  output logic signed [2*CB:0]   cross_a,
  output logic signed [2*CB:0]   cross_b,
  output logic signed [2*CB+2:0] cross_c,
  output offset_flags_t          flags
);

  localparam logic [CB+1:0] CAP = (CB+2)'(1) << (CB-1);

  // Magnitude of an offset, saturated at 2^(CB-1)
  function automatic logic [CB-1:0] sat_mag(input logic signed [CB+1:0] d);
    logic [CB+1:0] du;
    logic [CB+1:0] m;
    du = d;
    m  = d[CB+1] ? ((~du) + (CB+2)'(1)) : du;
    if (m > CAP) begin
      m = CAP;
    end
    return m[CB-1:0];
  endfunction

  logic signed [CB:0]   ox1;
  logic signed [CB:0]   oy1;
  logic signed [CB+1:0] ox2;
  logic signed [CB+1:0] oy2;
  logic signed [CB+2:0] noy2;
  logic signed [CB-1:0] ws;
  logic signed [CB-1:0] hs;
  logic        [CB-1:0] mx1, mx2, my1, my2;

  assign ox1  = (CB+1)'(point_x) - (CB+1)'(rect_left);
  assign oy1  = (CB+1)'(point_y) - (CB+1)'(rect_top);
  assign ox2  = (CB+2)'(ox1) - $signed({3'b000, rect_width});
  assign oy2  = (CB+2)'(oy1) - $signed({3'b000, rect_height});
  assign noy2 = -((CB+3)'(oy2));
  assign ws   = $signed({1'b0, rect_width});
  assign hs   = $signed({1'b0, rect_height});

  assign mx1 = sat_mag((CB+2)'(ox1));
  assign my1 = sat_mag((CB+2)'(oy1));
  assign mx2 = sat_mag(ox2);
  assign my2 = sat_mag(oy2);

  // One multiplier deep; register every product
  always_ff @(posedge clk) begin
    sq_x1   <= (2*CB)'(mx1) * (2*CB)'(mx1);
    sq_x2   <= (2*CB)'(mx2) * (2*CB)'(mx2);
    sq_y1   <= (2*CB)'(my1) * (2*CB)'(my1);
    sq_y2   <= (2*CB)'(my2) * (2*CB)'(my2);
    r_sq    <= (2*CB-2)'(corner_radius) * (2*CB-2)'(corner_radius);
    cross_a <= (2*CB+1)'(hs) * (2*CB+1)'(ox1);
    cross_b <= (2*CB+1)'(ws) * (2*CB+1)'(oy1);
    cross_c <= (2*CB+3)'(ws) * noy2;
    flags.ox1_neg  <= ox1[CB];
    flags.ox1_zero <= (ox1 == '0);
    flags.ox2_neg  <= ox2[CB+1];
    flags.ox2_zero <= (ox2 == '0);
    flags.oy1_neg  <= oy1[CB];
    flags.oy2_neg  <= oy2[CB+1];
    flags.oy2_zero <= (oy2 == '0);
  end

endmodule

FILE: hw/rtl/rrc_decide.sv
module rrc_decide
  import rrc_pkg::*;
#(
  parameter int CB = 16
) (
  input  logic                   clk,
  input  logic        [2*CB-1:0] sq_x1,
  input  logic        [2*CB-1:0] sq_x2,
  input  logic        [2*CB-1:0] sq_y1,
  input  logic        [2*CB-1:0] sq_y2,
  input  logic        [2*CB-3:0] r_sq,
  input  logic signed [2*CB:0]   cross_a,
  input  logic signed [2*CB:0]   cross_b,
  input  logic signed [2*CB+2:0] cross_c,
  input  offset_flags_t          flags,
  output region_t                region
);

  localparam int SW = 2*CB+1;
  localparam int XW = 2*CB+3;

  logic [SW-1:0] r2;
  logic [SW-1:0] sq_dx, sq_dy;
  logic          outside;
  logic          near_tl, near_tr, near_br, near_bl;
  logic          h1, h2;
  region_t       region_next;

  assign r2 = SW'(r_sq);

  // Clamped distance: left of the box uses the left offset, right of it the right one
  assign sq_dx = flags.ox1_neg ? SW'(sq_x1)
               : (!flags.ox2_neg && !flags.ox2_zero) ? SW'(sq_x2) : '0;
  assign sq_dy = flags.oy1_neg ? SW'(sq_y1)
               : (!flags.oy2_neg && !flags.oy2_zero) ? SW'(sq_y2) : '0;

  assign outside = (sq_dx + sq_dy) > r2;

  assign near_tl = ((SW'(sq_x1) + SW'(sq_y1)) <= r2)
                   && (flags.ox1_neg || flags.ox1_zero) && flags.oy1_neg;
  assign near_tr = ((SW'(sq_x2) + SW'(sq_y1)) <= r2)
                   && !flags.ox2_neg && !flags.ox2_zero && flags.oy1_neg;
  assign near_br = ((SW'(sq_x2) + SW'(sq_y2)) <= r2)
                   && !flags.ox2_neg && !flags.oy2_neg;
  assign near_bl = ((SW'(sq_x1) + SW'(sq_y2)) <= r2)
                   && flags.ox1_neg && !flags.oy2_neg;

  // Diagonal tests by cross products
  assign h1 = XW'(cross_a) > XW'(cross_b);
  assign h2 = cross_c > XW'(cross_a);

  always_comb begin
    priority if (outside) begin
      region_next = REGION_OUTSIDE;
    end else if (near_tl) begin
      region_next = REGION_CORNER_TL;
    end else if (near_tr) begin
      region_next = REGION_CORNER_TR;
    end else if (near_br) begin
      region_next = REGION_CORNER_BR;
    end else if (near_bl) begin
      region_next = REGION_CORNER_BL;
    end else if (h1 && h2) begin
      region_next = REGION_TOP;
    end else if (h2) begin
      region_next = REGION_LEFT;
    end else if (h1) begin
      region_next = REGION_RIGHT;
    end else begin
      region_next = REGION_BOTTOM;
    end
  end

  always_ff @(posedge clk) begin
    region <= region_next;
  end

endmodule

FILE: hw/rtl/rounded_rect_region_classify_unit.sv
// Channel   Direction  Handshake              Payload
// query     in         start high, busy low   rect_left, rect_top, rect_width, rect_height,
//                                             corner_radius, point_x, point_y
// result    out        done high, one cycle   region
//
// A query's result comes out with done high after the input, product and result registers.
// One query is accepted every cycle; busy is held low, since the three-stage pipeline
// (input register, product register, result register) never blocks.
// The receiver cannot stall: each result is shown for exactly one cycle.
// Synchronous active-high reset clears the valid bits of all stages; payload is not reset.
module rounded_rect_region_classify_unit
  import rrc_pkg::*;
#(
  parameter int COORD_BITS = 16
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  output logic                         busy,
  input  logic signed [COORD_BITS-1:0] rect_left,
  input  logic signed [COORD_BITS-1:0] rect_top,
  input  logic        [COORD_BITS-2:0] rect_width,
  input  logic        [COORD_BITS-2:0] rect_height,
  input  logic        [COORD_BITS-2:0] corner_radius,
  input  logic signed [COORD_BITS-1:0] point_x,
  input  logic signed [COORD_BITS-1:0] point_y,
  output logic                         done,
  output logic        [3:0]            region
);

  localparam int CB = COORD_BITS;

  // Stage 1: input register
  logic signed [CB-1:0] in_left, in_top, in_px, in_py;
  logic        [CB-2:0] in_w, in_h, in_r;
  logic                 in_valid;

  // Stage 2: products and offset flags
  logic        [2*CB-1:0] sq_x1, sq_x2, sq_y1, sq_y2;
  logic        [2*CB-3:0] r_sq;
  logic signed [2*CB:0]   cross_a, cross_b;
  logic signed [2*CB+2:0] cross_c;
  offset_flags_t          flags;
  logic                   prod_valid;

  // Stage 3: result register
  region_t                region_q;
  logic                   out_valid;

  // Never hold off a query
  assign busy = 1'b0;

  // Capture the query on every transaction; payload needs no reset
  always_ff @(posedge clk) begin
    if (start && !busy) begin
      in_left <= rect_left;
      in_top  <= rect_top;
      in_w    <= rect_width;
      in_h    <= rect_height;
      in_r    <= corner_radius;
      in_px   <= point_x;
      in_py   <= point_y;
    end
  end

  // Advance the valid bits alongside the data
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid   <= 1'b0;
      prod_valid <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      in_valid   <= start && !busy;
      prod_valid <= in_valid;
      out_valid  <= prod_valid;
    end
  end

  rrc_products #(.CB(CB)) u_products (
    .clk           (clk),
    .rect_left     (in_left),
    .rect_top      (in_top),
    .rect_width    (in_w),
    .rect_height   (in_h),
    .corner_radius (in_r),
    .point_x       (in_px),
    .point_y       (in_py),
    .sq_x1         (sq_x1),
    .sq_x2         (sq_x2),
    .sq_y1         (sq_y1),
    .sq_y2         (sq_y2),
    .r_sq          (r_sq),
    .cross_a       (cross_a),
    .cross_b       (cross_b),
    .cross_c       (cross_c),
    .flags         (flags)
  );

  // Outside test, corner arcs in fixed order, then diagonal split into sides
  rrc_decide #(.CB(CB)) u_decide (
    .clk     (clk),
    .sq_x1   (sq_x1),
    .sq_x2   (sq_x2),
    .sq_y1   (sq_y1),
    .sq_y2   (sq_y2),
    .r_sq    (r_sq),
    .cross_a (cross_a),
    .cross_b (cross_b),
    .cross_c (cross_c),
    .flags   (flags),
    .region  (region_q)
  );

  assign done   = out_valid;
  assign region = region_q;

endmodule

FILE: tb/sv/tb_rounded_rect_region_classify_unit.sv
module tb_rounded_rect_region_classify_unit;
  import rrc_pkg::*;

  localparam int CB          = 16;
  // Offsets are clamped to this magnitude before squaring.
  localparam longint OFS_CAP = longint'(1) << (CB - 1);
  localparam int RANDOM_QUERIES = 900;
  localparam int DRAIN_AT       = 600;      // pause the sender here until all results return
  localparam int QUIET_FIRST    = 300;      // random queries in [QUIET_FIRST, QUIET_LAST) never idle
  localparam int QUIET_LAST     = 500;
  localparam int TAIL_CYCLES    = 12;       // pipeline is three stages deep
  localparam int CYCLE_LIMIT    = 200000;

  // One query transaction: base rectangle, radius and point.
  typedef struct {
    logic signed [CB-1:0] left;
    logic signed [CB-1:0] top;
    logic        [CB-2:0] width;
    logic        [CB-2:0] height;
    logic        [CB-2:0] radius;
    logic signed [CB-1:0] px;
    logic signed [CB-1:0] py;
  } query_t;

  // Directed table row: the query and, where obvious, the region it must give.
  typedef struct {
    query_t  q;
    bit      known;
    region_t region;
  } dir_row_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 start = 1'b0;
  logic                 busy;
  logic signed [CB-1:0] rect_left = '0;
  logic signed [CB-1:0] rect_top = '0;
  logic        [CB-2:0] rect_width = '0;
  logic        [CB-2:0] rect_height = '0;
  logic        [CB-2:0] corner_radius = '0;
  logic signed [CB-1:0] point_x = '0;
  logic signed [CB-1:0] point_y = '0;
  logic                 done;
  logic        [3:0]    region;

  region_t  expected_regions[$];   // oldest expected region at the front
  dir_row_t directed[$];
  int       error_count = 0;
  int       sent_count = 0;
  int       checked_count = 0;
  int       region_hits[9];
  int       cycle_count = 0;

  rounded_rect_region_classify_unit #(
    .COORD_BITS(CB)
  ) dut (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .rect_left    (rect_left),
    .rect_top     (rect_top),
    .rect_width   (rect_width),
    .rect_height  (rect_height),
    .corner_radius(corner_radius),
    .point_x      (point_x),
    .point_y      (point_y),
    .done         (done),
    .region       (region)
  );

  // 4 time unit clock period.
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Region predictor: exact integer geometry at 64 bits, so nothing overflows.
  // ---------------------------------------------------------------------------

  // Square of |d| with |d| clamped; a clamped offset is beyond any radius anyway.
  function automatic longint clamped_square(longint d);
    longint m;
    m = (d < 0) ? -d : d;
    if (m > OFS_CAP) m = OFS_CAP;
    return m * m;
  endfunction

  function automatic longint max_of3(longint a, longint b, longint c);
    longint m;
    m = (a > b) ? a : b;
    return (m > c) ? m : c;
  endfunction

  function automatic region_t classify_point(query_t q);
    longint l, t, w, h, r2, px, py, dx, dy, ox, oy, a;
    bit     h1, h2;
    l  = longint'(q.left);
    t  = longint'(q.top);
    w  = longint'(q.width);
    h  = longint'(q.height);
    px = longint'(q.px);
    py = longint'(q.py);
    r2 = longint'(q.radius) * longint'(q.radius);

    // Distance from the point to the base rectangle, zero inside it.
    dx = max_of3(l - px, 0, px - l - w);
    dy = max_of3(t - py, 0, py - t - h);
    if (clamped_square(dx) + clamped_square(dy) > r2) return REGION_OUTSIDE;

    // Corner arcs in fixed priority; each owns a half-open quadrant so that
    // points on the axes through a corner land in exactly one arc.
    ox = px - l;
    oy = py - t;
    if (clamped_square(ox) + clamped_square(oy) <= r2 && ox <= 0 && oy < 0)
      return REGION_CORNER_TL;
    ox = px - (l + w);
    if (clamped_square(ox) + clamped_square(oy) <= r2 && ox > 0 && oy < 0)
      return REGION_CORNER_TR;
    oy = py - (t + h);
    if (clamped_square(ox) + clamped_square(oy) <= r2 && ox >= 0 && oy >= 0)
      return REGION_CORNER_BR;
    ox = px - l;
    if (clamped_square(ox) + clamped_square(oy) <= r2 && ox < 0 && oy >= 0)
      return REGION_CORNER_BL;

    // Sides: which side of each diagonal, by cross products (no division,
    // so zero width or height stays well defined).
    a  = h * (px - l);
    h1 = a > w * (py - t);
    h2 = w * (t + h - py) > a;
    if (h1 && h2) return REGION_TOP;
    if (h2)       return REGION_LEFT;
    if (h1)       return REGION_RIGHT;
    return REGION_BOTTOM;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  function automatic dir_row_t mk_row(int l, int t, int w, int h, int r, int px, int py,
                                      bit known, region_t reg_code);
    dir_row_t d;
    d.q.left   = l[CB-1:0];
    d.q.top    = t[CB-1:0];
    d.q.width  = w[CB-2:0];
    d.q.height = h[CB-2:0];
    d.q.radius = r[CB-2:0];
    d.q.px     = px[CB-1:0];
    d.q.py     = py[CB-1:0];
    d.known    = known;
    d.region   = reg_code;
    return d;
  endfunction

  // Append one row at the end of the directed table.
  function automatic void add_row(dir_row_t d);
    directed.insert(directed.size(), d);
  endfunction

  // Mostly rectangles with a point near them, so every region gets hit;
  // a few fully random queries hit the saturation and wraparound paths.
  function automatic query_t random_query();
    query_t      q;
    int unsigned mode, size_max;
    int          off_x, off_y;
    mode = $urandom_range(0, 15);
    if (mode < 2) begin
      q.left   = CB'($urandom());
      q.top    = CB'($urandom());
      q.width  = (CB-1)'($urandom());
      q.height = (CB-1)'($urandom());
      q.radius = (CB-1)'($urandom());
      q.px     = CB'($urandom());
      q.py     = CB'($urandom());
    end else begin
      size_max = (mode < 10) ? 255 : ((mode < 14) ? 4095 : 32767);
      q.width  = (CB-1)'($urandom_range(0, size_max));
      q.height = (CB-1)'($urandom_range(0, size_max));
      q.radius = ($urandom_range(0, 9) == 0) ? '0 : (CB-1)'($urandom_range(0, size_max));
      q.left   = CB'($urandom());
      q.top    = CB'($urandom());
      off_x = int'($urandom_range(0, int'(q.width) + 2 * int'(q.radius) + 32))
              - (int'(q.radius) + 16);
      off_y = int'($urandom_range(0, int'(q.height) + 2 * int'(q.radius) + 32))
              - (int'(q.radius) + 16);
      q.px = CB'(int'(q.left) + off_x);
      q.py = CB'(int'(q.top) + off_y);
    end
    return q;
  endfunction

  task automatic drive_fields(query_t q);
    rect_left     <= q.left;
    rect_top      <= q.top;
    rect_width    <= q.width;
    rect_height   <= q.height;
    corner_radius <= q.radius;
    point_x       <= q.px;
    point_y       <= q.py;
  endtask

  // Present one query and hold it until the block takes it; record what it must give.
  task automatic issue_query(query_t q, bit known, region_t typed_region);
    drive_fields(q);
    start <= 1'b1;
    do @(posedge clk); while (busy !== 1'b0);
    expected_regions.insert(expected_regions.size(),
                            known ? typed_region : classify_point(q));
    sent_count++;
  endtask

  // Drop start for a few cycles at random; the ignored fields carry noise meanwhile.
  task automatic maybe_idle(bit quiet);
    int n;
    if (!quiet && $urandom_range(0, 99) < 8) begin
      n = int'($urandom_range(1, 4));
      start <= 1'b0;
      drive_fields(random_query());
      repeat (n) @(posedge clk);
    end
  endtask

  // ---------------------------------------------------------------------------
  // Directed table
  // ---------------------------------------------------------------------------
  initial begin
    // Sides of a 10x10 pixel square with a 2 pixel radius.
    add_row(mk_row(0, 0, 160, 160, 32, 80, 0, 1, REGION_TOP));
    add_row(mk_row(0, 0, 160, 160, 32, 160, 80, 1, REGION_RIGHT));
    add_row(mk_row(0, 0, 160, 160, 32, 80, 160, 1, REGION_BOTTOM));
    add_row(mk_row(0, 0, 160, 160, 32, 0, 80, 1, REGION_LEFT));
    // The four corner arcs.
    add_row(mk_row(0, 0, 160, 160, 32, -10, -10, 1, REGION_CORNER_TL));
    add_row(mk_row(0, 0, 160, 160, 32, 170, -10, 1, REGION_CORNER_TR));
    add_row(mk_row(0, 0, 160, 160, 32, 170, 170, 1, REGION_CORNER_BR));
    add_row(mk_row(0, 0, 160, 160, 32, -10, 170, 1, REGION_CORNER_BL));
    add_row(mk_row(0, 0, 160, 160, 32, -100, -100, 1, REGION_OUTSIDE));
    // Exactly on the rounded edge, then one step beyond it.
    add_row(mk_row(0, 0, 160, 160, 32, -32, 80, 0, REGION_OUTSIDE));
    add_row(mk_row(0, 0, 160, 160, 32, -33, 80, 1, REGION_OUTSIDE));
    // Quadrant boundaries right at a corner.
    add_row(mk_row(0, 0, 160, 160, 32, 0, -5, 0, REGION_OUTSIDE));
    add_row(mk_row(0, 0, 160, 160, 32, 1, -5, 0, REGION_OUTSIDE));
    add_row(mk_row(0, 0, 160, 160, 32, 160, 160, 0, REGION_OUTSIDE));
    // Field extremes: offsets that saturate before squaring.
    add_row(mk_row(-32768, -32768, 32767, 32767, 32767, 32767, 32767,
                   1, REGION_OUTSIDE));
    add_row(mk_row(32767, 32767, 0, 0, 0, -32768, -32768, 1, REGION_OUTSIDE));
    add_row(mk_row(-32768, -32768, 32767, 32767, 32767, -32768, -32768,
                   0, REGION_OUTSIDE));
    add_row(mk_row(0, 0, 1, 1, 32767, -32768, 0, 0, REGION_OUTSIDE));
    add_row(mk_row(-32768, -32768, 1, 1, 0, -32768, -32768, 0, REGION_OUTSIDE));
    // Zero radius: only the rectangle itself, and the bottom-right arc only on its corner point.
    add_row(mk_row(0, 0, 16, 16, 0, 0, 0, 0, REGION_OUTSIDE));
    add_row(mk_row(0, 0, 16, 16, 0, 16, 16, 1, REGION_CORNER_BR));
    add_row(mk_row(0, 0, 16, 16, 0, 8, 8, 0, REGION_OUTSIDE));
    // Zero width, zero height, and both.
    add_row(mk_row(0, 0, 0, 64, 16, 0, 32, 0, REGION_OUTSIDE));
    add_row(mk_row(0, 0, 64, 0, 16, 32, 0, 0, REGION_OUTSIDE));
    add_row(mk_row(5, 5, 0, 0, 0, 5, 5, 1, REGION_CORNER_BR));
  end

  // ---------------------------------------------------------------------------
  // Sender: reset, directed table, random queries, one full drain, then wrap up.
  // ---------------------------------------------------------------------------
  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (directed[i]) begin
      issue_query(directed[i].q, directed[i].known, directed[i].region);
      maybe_idle(1'b0);
    end

    for (int i = 0; i < RANDOM_QUERIES; i++) begin
      issue_query(random_query(), 1'b0, REGION_OUTSIDE);
      if (i == DRAIN_AT) begin
        // Hold off until the pipeline has emptied completely.
        start <= 1'b0;
        while (expected_regions.size() != 0) @(posedge clk);
      end else begin
        maybe_idle(i >= QUIET_FIRST && i < QUIET_LAST);
      end
    end

    start <= 1'b0;
    while (expected_regions.size() != 0) @(posedge clk);
    // Give any stray result time to show up.
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("Sent %0d query transactions (%0d from the directed table), checked %0d results",
             sent_count, directed.size(), checked_count);
    $display("Regions out/top/right/bottom/left/TL/TR/BR/BL: %0d %0d %0d %0d %0d %0d %0d %0d %0d",
             region_hits[0], region_hits[1], region_hits[2], region_hits[3], region_hits[4],
             region_hits[5], region_hits[6], region_hits[7], region_hits[8]);
    if (error_count == 0 && expected_regions.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Result checker: done marks one result for one cycle, taken at the closing edge.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    region_t exp_region;
    if (!rst && done === 1'b1) begin
      if (expected_regions.size() == 0) begin
        $error("region: no transaction outstanding, actual %0d", region);
        error_count++;
      end else begin
        exp_region = expected_regions.pop_front();
        checked_count++;
        if (region !== exp_region) begin
          $error("region: expected %0d, actual %0d", exp_region, region);
          error_count++;
        end
      end
      if (region < 9) region_hits[region]++;
    end
  end

  // Watchdog: end the run if it hangs.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

endmodule

FILE: sim.f
hw/rtl/rrc_pkg.sv
hw/rtl/rrc_products.sv
hw/rtl/rrc_decide.sv
hw/rtl/rounded_rect_region_classify_unit.sv
tb/sv/tb_rounded_rect_region_classify_unit.sv
